### src/page_framebuffer_draw_engine_defines.svh
// Assertion macros for the page framebuffer draw engine checkers.
// No dependencies; expects signals named clock and reset in the using scope.
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define PFDE_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pfde check failed");

// Next-cycle implication, checked at every rising clock edge outside reset
`define PFDE_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pfde check failed");

`endif

### src/pfde_pkg.sv
// Shared constants, codes and types of the page framebuffer draw engine.
// No dependencies.
`default_nettype none

package pfde_pkg;

   // Display geometry
   localparam int WIDTH       = 128;
   localparam int PAGES       = 8;
   localparam int ROWS        = PAGES * 8;
   localparam int STORE_BYTES = WIDTH * PAGES;
   localparam int ADDR_W      = $clog2(STORE_BYTES);

   // Bar percent clamp and division by 100 as multiply by reciprocal
   localparam int PCT_MAX     = 100;
   localparam int RECIP       = 5243;
   localparam int RECIP_SHIFT = 19;

   // Command codes
   typedef enum logic [2:0] {
      CMD_CLEAR = 3'd0,
      CMD_PIXEL = 3'd1,
      CMD_HLINE = 3'd2,
      CMD_VLINE = 3'd3,
      CMD_RECT  = 3'd4,
      CMD_FILL  = 3'd5,
      CMD_BAR   = 3'd6,
      CMD_READ  = 3'd7
   } cmd_type;

   // Operations of the pixel engine
   typedef enum logic [1:0] {
      OP_SPAN  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   // One request to the pixel engine: a run of pixels, a clear or a read
   typedef struct packed {
      op_type     op;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] len;
      logic       vert;
      logic       on;
      logic [9:0] index;
   } eng_cmd_type;

   // Pixel engine status
   typedef struct packed {
      logic idle;
      logic done;
   } eng_stat_type;

endpackage

`default_nettype wire

### src/pfde_if.sv
// Valid/ready channel interfaces for draw commands and read responses.
// No dependencies.
`default_nettype none

interface pfde_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [7:0] x;
   logic [7:0] y;
   logic [7:0] width;
   logic [7:0] height;
   logic [7:0] value;
   logic [9:0] byte_index;

   modport source (output valid, command, x, y, width, height, value, byte_index,
                   input ready);
   modport sink   (input valid, command, x, y, width, height, value, byte_index,
                   output ready);
endinterface

interface pfde_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

### src/page_framebuffer_draw_engine.sv
// Drawing engine over a page-organised monochrome framebuffer of 128 x 64
// pixels (1024 bytes, 8 vertical pixels a byte). One command is taken at a
// time; req_ch.ready stays low until its response is in the output register.
// Every on-display pixel goes through the store as a read, then a modify
// and write; an off-display pixel is dropped without a store access. Each
// run of pixels (a line, an outline edge, a filled row) is one request to
// the pixel engine. A bar adds a multiply and a divide step for the inset
// width, then fills the inset. Clear sweeps the store one byte a cycle.
// After reset the same sweep runs before the first command is accepted.
// Depends on pfde_pkg, pfde_if, pfde_engine and pfde_seq.
`default_nettype none

module page_framebuffer_draw_engine (
   input wire logic clock,
   input wire logic reset,
   pfde_req_if.sink   req_ch,
   pfde_rsp_if.source rsp_ch
);

   logic                   ready;
   logic                   req_fire;
   logic                   start;
   pfde_pkg::eng_cmd_type  eng_cmd;
   pfde_pkg::eng_stat_type eng_stat;
   logic [7:0]             eng_rd;
   logic                   out_free;
   logic                   fin;
   logic [7:0]             result;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_data_ff, rsp_data_in;

   assign req_ch.ready = ready;
   assign req_fire     = req_ch.valid && ready;

   pfde_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .req_command    (req_ch.command),
      .req_x          (req_ch.x),
      .req_y          (req_ch.y),
      .req_width      (req_ch.width),
      .req_height     (req_ch.height),
      .req_value      (req_ch.value),
      .req_byte_index (req_ch.byte_index),
      .ready          (ready),
      .start          (start),
      .eng_cmd        (eng_cmd),
      .eng_stat       (eng_stat),
      .eng_rd         (eng_rd),
      .out_free       (out_free),
      .fin            (fin),
      .result         (result)
   );

   pfde_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .cmd     (eng_cmd),
      .stat    (eng_stat),
      .rd_data (eng_rd)
   );

   // Output register: holds the response transaction until taken
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fin) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.read_data = rsp_data_ff;

endmodule

`default_nettype wire

### src/pfde_ram.sv
// Framebuffer store: one write port, one read port with registered data.
// Depends on pfde_pkg.
`default_nettype none

module pfde_ram (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [pfde_pkg::ADDR_W-1:0] waddr,
   input  wire logic [7:0]                 wdata,
   input  wire logic [pfde_pkg::ADDR_W-1:0] raddr,
   output      logic [7:0]                 rdata
);

   logic [7:0] mem [pfde_pkg::STORE_BYTES];
   logic [7:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### src/pfde_engine.sv
// Pixel engine: walks a run of pixels with read-modify-write, sweeps the
// store to zero, or reads one byte. Depends on pfde_pkg and pfde_ram.
`default_nettype none

module pfde_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire pfde_pkg::eng_cmd_type cmd,
   output      pfde_pkg::eng_stat_type stat,
   output      logic [7:0]            rd_data
);

   typedef enum logic [4:0] {
      E_IDLE   = 5'b00001,
      E_STEP   = 5'b00010,
      E_WRITE  = 5'b00100,
      E_CLEAR  = 5'b01000,
      E_RDWAIT = 5'b10000
   } eng_state_type;

   eng_state_type               state_ff, state_in;
   logic [7:0]                  cx_ff, cx_in;
   logic [7:0]                  cy_ff, cy_in;
   logic [7:0]                  len_ff, len_in;
   logic                        vert_ff, vert_in;
   logic                        on_ff, on_in;
   logic [pfde_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [7:0]                  mask_ff, mask_in;
   logic                        rvalid_ff, rvalid_in;
   logic [7:0]                  rd_ff, rd_in;
   logic                        done_ff, done_in;

   logic                        we;
   logic [pfde_pkg::ADDR_W-1:0] waddr;
   logic [7:0]                  wdata;
   logic [pfde_pkg::ADDR_W-1:0] raddr;
   logic [7:0]                  ram_rdata;
   logic [pfde_pkg::ADDR_W-1:0] pix_addr;
   logic                        on_disp;

   pfde_ram u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   // Current pixel position in the store; valid only when on display
   assign pix_addr = pfde_pkg::ADDR_W'(32'(cx_ff) + 32'(cy_ff[7:3]) * pfde_pkg::WIDTH);
   assign on_disp  = (32'(cx_ff) < pfde_pkg::WIDTH) && (32'(cy_ff) < pfde_pkg::ROWS);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      len_in    = len_ff;
      vert_in   = vert_ff;
      on_in     = on_ff;
      addr_in   = addr_ff;
      mask_in   = mask_ff;
      rvalid_in = rvalid_ff;
      rd_in     = rd_ff;
      done_in   = 1'b0;
      we        = 1'b0;
      waddr     = addr_ff;
      wdata     = 8'h00;
      raddr     = pix_addr;
      case (state_ff)
         E_IDLE: begin
            if (start) begin
               cx_in   = cmd.x;
               cy_in   = cmd.y;
               len_in  = cmd.len;
               vert_in = cmd.vert;
               on_in   = cmd.on;
               case (cmd.op)
                  pfde_pkg::OP_CLEAR: begin
                     addr_in  = '0;
                     state_in = E_CLEAR;
                  end
                  pfde_pkg::OP_READ: begin
                     raddr     = pfde_pkg::ADDR_W'(cmd.index);
                     rvalid_in = 32'(cmd.index) < pfde_pkg::STORE_BYTES;
                     state_in  = E_RDWAIT;
                  end
                  default: begin
                     state_in = E_STEP;
                  end
               endcase
            end
         end
         E_STEP: begin
            if (len_ff == 8'd0) begin
               done_in  = 1'b1;
               state_in = E_IDLE;
            end else if (on_disp) begin
               // issue the read; modify and write next cycle
               addr_in  = pix_addr;
               mask_in  = 8'd1 << cy_ff[2:0];
               state_in = E_WRITE;
            end else begin
               // off display: drop the pixel
               len_in = len_ff - 8'd1;
               if (vert_ff) begin
                  cy_in = cy_ff + 8'd1;
               end else begin
                  cx_in = cx_ff + 8'd1;
               end
            end
         end
         E_WRITE: begin
            we     = 1'b1;
            wdata  = on_ff ? (ram_rdata | mask_ff) : (ram_rdata & ~mask_ff);
            len_in = len_ff - 8'd1;
            if (vert_ff) begin
               cy_in = cy_ff + 8'd1;
            end else begin
               cx_in = cx_ff + 8'd1;
            end
            state_in = E_STEP;
         end
         E_CLEAR: begin
            we = 1'b1;
            if (addr_ff == pfde_pkg::ADDR_W'(pfde_pkg::STORE_BYTES - 1)) begin
               done_in  = 1'b1;
               state_in = E_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         E_RDWAIT: begin
            rd_in    = rvalid_ff ? ram_rdata : 8'h00;
            done_in  = 1'b1;
            state_in = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   // Control registers; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_CLEAR;
         addr_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         done_ff  <= done_in;
      end
   end

   // Walk registers
   always_ff @(posedge clock) begin
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      len_ff    <= len_in;
      vert_ff   <= vert_in;
      on_ff     <= on_in;
      mask_ff   <= mask_in;
      rvalid_ff <= rvalid_in;
      rd_ff     <= rd_in;
   end

   assign stat.idle = (state_ff == E_IDLE);
   assign stat.done = done_ff;
   assign rd_data   = rd_ff;

endmodule

`default_nettype wire

### src/pfde_seq.sv
// Command sequencer: breaks each draw command into pixel runs, or a clear
// or a read, for the pixel engine and computes the bar inset. Depends on pfde_pkg.
`default_nettype none

module pfde_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_fire,
   input  wire logic [2:0]             req_command,
   input  wire logic [7:0]             req_x,
   input  wire logic [7:0]             req_y,
   input  wire logic [7:0]             req_width,
   input  wire logic [7:0]             req_height,
   input  wire logic [7:0]             req_value,
   input  wire logic [9:0]             req_byte_index,
   output      logic                   ready,
   output      logic                   start,
   output      pfde_pkg::eng_cmd_type  eng_cmd,
   input  wire pfde_pkg::eng_stat_type eng_stat,
   input  wire logic [7:0]             eng_rd,
   input  wire logic                   out_free,
   output      logic                   fin,
   output      logic [7:0]             result
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b00000001,
      S_SINGLE  = 8'b00000010,
      S_OUTLINE = 8'b00000100,
      S_FILL    = 8'b00001000,
      S_WAIT    = 8'b00010000,
      S_MUL     = 8'b00100000,
      S_DIV     = 8'b01000000,
      S_DONE    = 8'b10000000
   } seq_state_type;

   typedef enum logic [1:0] {
      PH_SINGLE  = 2'd0,
      PH_OUTLINE = 2'd1,
      PH_FILL    = 2'd2
   } phase_type;

   seq_state_type     state_ff, state_in;
   phase_type         phase_ff, phase_in;
   pfde_pkg::cmd_type cmd_ff, cmd_in;
   logic [7:0]        x_ff, x_in;
   logic [7:0]        y_ff, y_in;
   logic [7:0]        w_ff, w_in;
   logic [7:0]        h_ff, h_in;
   logic [6:0]        pct_ff, pct_in;
   logic              on_ff, on_in;
   logic [9:0]        index_ff, index_in;
   logic [1:0]        part_ff, part_in;
   logic [7:0]        row_ff, row_in;
   logic [7:0]        fx_ff, fx_in;
   logic [7:0]        fy_ff, fy_in;
   logic [7:0]        fw_ff, fw_in;
   logic [7:0]        fh_ff, fh_in;
   logic [14:0]       prod_ff, prod_in;
   logic [7:0]        iw;

   // Inset width: floor(prod / 100)
   assign iw = 8'((32'(prod_ff) * pfde_pkg::RECIP) >> pfde_pkg::RECIP_SHIFT);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      pct_in   = pct_ff;
      on_in    = on_ff;
      index_in = index_ff;
      part_in  = part_ff;
      row_in   = row_ff;
      fx_in    = fx_ff;
      fy_in    = fy_ff;
      fw_in    = fw_ff;
      fh_in    = fh_ff;
      prod_in  = prod_ff;
      start    = 1'b0;
      fin      = 1'b0;
      result   = 8'h00;
      eng_cmd  = '{op: pfde_pkg::OP_SPAN, x: x_ff, y: y_ff, len: 8'd0,
                   vert: 1'b0, on: 1'b1, index: index_ff};
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in   = pfde_pkg::cmd_type'(req_command);
               x_in     = req_x;
               y_in     = req_y;
               w_in     = req_width;
               h_in     = req_height;
               pct_in   = (32'(req_value) > pfde_pkg::PCT_MAX) ?
                          7'(pfde_pkg::PCT_MAX) : req_value[6:0];
               on_in    = (req_value != 8'h00);
               index_in = req_byte_index;
               part_in  = 2'd0;
               row_in   = 8'd0;
               fx_in    = req_x;
               fy_in    = req_y;
               fw_in    = req_width;
               fh_in    = req_height;
               case (pfde_pkg::cmd_type'(req_command))
                  pfde_pkg::CMD_RECT, pfde_pkg::CMD_BAR: state_in = S_OUTLINE;
                  pfde_pkg::CMD_FILL:                    state_in = S_FILL;
                  default:                               state_in = S_SINGLE;
               endcase
            end
         end
         S_SINGLE: begin
            start    = 1'b1;
            phase_in = PH_SINGLE;
            state_in = S_WAIT;
            case (cmd_ff)
               pfde_pkg::CMD_CLEAR: eng_cmd.op = pfde_pkg::OP_CLEAR;
               pfde_pkg::CMD_READ:  eng_cmd.op = pfde_pkg::OP_READ;
               pfde_pkg::CMD_PIXEL: begin
                  eng_cmd.len = 8'd1;
                  eng_cmd.on  = on_ff;
               end
               pfde_pkg::CMD_HLINE: eng_cmd.len = w_ff;
               pfde_pkg::CMD_VLINE: begin
                  eng_cmd.len  = h_ff;
                  eng_cmd.vert = 1'b1;
               end
               default: eng_cmd.len = 8'd0;
            endcase
         end
         // Outline edges: top, bottom, left, right
         S_OUTLINE: begin
            start    = 1'b1;
            phase_in = PH_OUTLINE;
            state_in = S_WAIT;
            case (part_ff)
               2'd0: eng_cmd.len = w_ff;
               2'd1: begin
                  eng_cmd.y   = y_ff + h_ff - 8'd1;
                  eng_cmd.len = w_ff;
               end
               2'd2: begin
                  eng_cmd.len  = h_ff;
                  eng_cmd.vert = 1'b1;
               end
               default: begin
                  eng_cmd.x    = x_ff + w_ff - 8'd1;
                  eng_cmd.len  = h_ff;
                  eng_cmd.vert = 1'b1;
               end
            endcase
         end
         // One row of a filled area per run
         S_FILL: begin
            if (row_ff == fh_ff) begin
               state_in = S_DONE;
            end else begin
               start       = 1'b1;
               phase_in    = PH_FILL;
               eng_cmd.x   = fx_ff;
               eng_cmd.y   = fy_ff + row_ff;
               eng_cmd.len = fw_ff;
               state_in    = S_WAIT;
            end
         end
         S_WAIT: begin
            if (eng_stat.done) begin
               case (phase_ff)
                  PH_OUTLINE: begin
                     if (part_ff == 2'd3) begin
                        state_in = (cmd_ff == pfde_pkg::CMD_BAR) ? S_MUL : S_DONE;
                     end else begin
                        part_in  = part_ff + 2'd1;
                        state_in = S_OUTLINE;
                     end
                  end
                  PH_FILL: begin
                     row_in   = row_ff + 8'd1;
                     state_in = S_FILL;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_MUL: begin
            prod_in  = 15'(w_ff - 8'd2) * 15'(pct_ff);
            state_in = S_DIV;
         end
         S_DIV: begin
            fx_in    = x_ff + 8'd1;
            fy_in    = y_ff + 8'd1;
            fw_in    = iw;
            fh_in    = ((w_ff > 8'd2) && (h_ff > 8'd2) && (iw != 8'd0)) ?
                       (h_ff - 8'd2) : 8'd0;
            row_in   = 8'd0;
            state_in = S_FILL;
         end
         S_DONE: begin
            if (out_free) begin
               fin      = 1'b1;
               result   = (cmd_ff == pfde_pkg::CMD_READ) ? eng_rd : 8'h00;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Command and walk registers
   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      cmd_ff   <= cmd_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      w_ff     <= w_in;
      h_ff     <= h_in;
      pct_ff   <= pct_in;
      on_ff    <= on_in;
      index_ff <= index_in;
      part_ff  <= part_in;
      row_ff   <= row_in;
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      fw_ff    <= fw_in;
      fh_ff    <= fh_in;
      prod_ff  <= prod_in;
   end

   assign ready = (state_ff == S_IDLE) && eng_stat.idle;

endmodule

`default_nettype wire

### src/pfde_checker.sv
// Port-level checks of the page framebuffer draw engine, bound to the top.
// Depends on page_framebuffer_draw_engine_defines.svh.
`default_nettype none

`include "page_framebuffer_draw_engine_defines.svh"

module pfde_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_data
);

   // A stalled response holds
   `PFDE_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data))

   // One command at a time: busy right after accepting a transaction
   `PFDE_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready)

   // Clearing pass after reset: nothing accepted straight away
   `PFDE_ASSERT_IMP(a_clear_after_reset, $past(reset), !req_ready)

   // A new response only comes while the command is still in progress
   `PFDE_ASSERT_IMP(a_rsp_from_busy, $rose(rsp_valid), !$past(req_ready))

endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_read_data (rsp_ch.read_data)
);

`default_nettype wire
